[rtl/dts_pkg.sv]
// Shared types, constants and helper functions of the DSL token scanner.
package dts_pkg;

   localparam int OFFSET_BITS = 16;
   localparam int LEN_BITS    = OFFSET_BITS + 1;
   localparam int CLIP_BITS   = (LEN_BITS > 17) ? LEN_BITS : 17;

   localparam int QUEUE_DEPTH = 8;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [3:0] KIND_SEL    = 4'd0;
   localparam logic [3:0] KIND_CODE   = 4'd1;
   localparam logic [3:0] KIND_ARROW  = 4'd2;
   localparam logic [3:0] KIND_LISTEN = 4'd3;
   localparam logic [3:0] KIND_IDENT  = 4'd4;
   localparam logic [3:0] KIND_LB     = 4'd5;
   localparam logic [3:0] KIND_RB     = 4'd6;
   localparam logic [3:0] KIND_COLON  = 4'd7;
   localparam logic [3:0] KIND_COMMA  = 4'd8;
   localparam logic [3:0] KIND_BAD    = 4'd9;
   localparam logic [3:0] KIND_EOF    = 4'd10;

   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_DASH   = 8'h2D;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_LOW_L  = 8'h6C;

   localparam logic [2:0] KW_LENGTH = 3'd6;

   typedef struct packed {
      logic [7:0] source_byte;
      logic       end_of_source;
   } req_type;

   typedef struct packed {
      logic [3:0]  token_kind;
      logic [15:0] token_offset;
      logic [15:0] token_length;
      logic        final_token;
   } rsp_type;

   function automatic logic is_space(input logic [7:0] c);
      return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
   endfunction

   function automatic logic is_word(input logic [7:0] c);
      return is_alpha(c) || (c >= 8'h30 && c <= 8'h39) || (c == CH_UNDER);
   endfunction

   // Characters of the keyword "listen", by match position.
   function automatic logic [7:0] kw_char(input logic [2:0] idx);
      logic [7:0] ch;
      case (idx)
         3'd0:    ch = 8'h6C;
         3'd1:    ch = 8'h69;
         3'd2:    ch = 8'h73;
         3'd3:    ch = 8'h74;
         3'd4:    ch = 8'h65;
         3'd5:    ch = 8'h6E;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic logic [15:0] clip16(input logic [LEN_BITS-1:0] v);
      logic [CLIP_BITS-1:0] w;
      w = CLIP_BITS'(v);
      return (w > CLIP_BITS'(17'h0FFFF)) ? 16'hFFFF : w[15:0];
   endfunction

   // Length from begin up to (not including) end, never below zero.
   function automatic logic [LEN_BITS-1:0] span(input logic [LEN_BITS-1:0] endp,
                                                 input logic [OFFSET_BITS-1:0] beg);
      logic [LEN_BITS-1:0] b;
      b = {1'b0, beg};
      return (endp > b) ? (endp - b) : '0;
   endfunction

   function automatic rsp_type make_rsp(input logic [3:0] kind,
                                        input logic [OFFSET_BITS-1:0] off,
                                        input logic [LEN_BITS-1:0] len,
                                        input logic fin);
      rsp_type r;
      r.token_kind   = kind;
      r.token_offset = clip16({1'b0, off});
      r.token_length = clip16(len);
      r.final_token  = fin;
      return r;
   endfunction

endpackage

[rtl/dsl_token_scanner.sv]
// DSL token scanner: byte-stream tokenizer with a small result queue.
// Queue entry: the results of a byte enter the result queue at the edge that takes the byte;
// rsp_ offers them from the registered queue once older results ahead of them have left.
// Throughput: one byte per cycle while the queue has room for three results
// (a byte yields up to three tokens); the eight-entry queue sets when req_ready drops.
// Reset clears the scan state, the byte position and the result queue at once.
module dsl_token_scanner (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  dts_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output dts_pkg::rsp_type rsp_data
);

   localparam logic [2:0] MODE_IDLE  = 3'd0;
   localparam logic [2:0] MODE_LB    = 3'd1;
   localparam logic [2:0] MODE_UND   = 3'd2;
   localparam logic [2:0] MODE_DASH  = 3'd3;
   localparam logic [2:0] MODE_IDENT = 3'd4;
   localparam logic [2:0] MODE_SEL   = 3'd5;
   localparam logic [2:0] MODE_CODE  = 3'd6;

   localparam int OB = dts_pkg::OFFSET_BITS;
   localparam int LB = dts_pkg::LEN_BITS;
   localparam logic [OB-1:0] POS_MAX = {OB{1'b1}};
   localparam logic [LB-1:0] LEN_ONE = LB'(1);
   localparam logic [LB-1:0] LEN_TWO = LB'(2);

   logic [2:0]    mode_ff,  mode_in;
   logic [OB-1:0] begin_ff, begin_in;
   logic [OB-1:0] pos_ff,   pos_in;
   logic [2:0]    kwp_ff,   kwp_in;
   logic          kwb_ff,   kwb_in;
   logic          half_ff,  half_in;

   dts_pkg::rsp_type queue_ff [dts_pkg::QUEUE_DEPTH];
   logic [dts_pkg::QPTR_BITS-1:0] head_ff, head_in;
   logic [dts_pkg::QPTR_BITS-1:0] tail_ff, tail_in;
   logic [dts_pkg::QCNT_BITS-1:0] count_ff, count_in;

   dts_pkg::rsp_type cand [4];
   logic [3:0]       cand_v;
   logic [1:0]       slot [4];
   logic [2:0]       push_n;

   logic          req_fire, rsp_fire;
   logic [7:0]    c;
   logic          last;
   logic [LB-1:0] endp;
   logic [3:0]    ident_kind;

   assign req_fire  = req_valid & req_ready;
   assign rsp_fire  = rsp_valid & rsp_ready;
   assign req_ready = (count_ff <= dts_pkg::QCNT_BITS'(dts_pkg::QUEUE_DEPTH - 3));
   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = queue_ff[head_ff];

   assign c          = req_data.source_byte;
   assign last       = req_data.end_of_source;
   assign endp       = {1'b0, pos_ff} + LEN_ONE;
   assign ident_kind = (!kwb_ff && kwp_ff == dts_pkg::KW_LENGTH) ?
                       dts_pkg::KIND_LISTEN : dts_pkg::KIND_IDENT;

   // Candidate order: pending-token flush, single-character token of the
   // new byte, end-of-source flush, end-of-file token.
   always_comb begin
      logic       restart;
      logic [7:0] closer;
      logic [3:0] blk_kind;
      restart  = 1'b0;
      closer   = dts_pkg::CH_RBRACE;
      blk_kind = dts_pkg::KIND_SEL;
      mode_in  = mode_ff;
      begin_in = begin_ff;
      kwp_in   = kwp_ff;
      kwb_in   = kwb_ff;
      half_in  = half_ff;
      cand_v   = '0;
      for (int i = 0; i < 4; i++) begin
         cand[i] = '0;
      end

      unique case (mode_ff) inside
         MODE_LB: begin
            if (c == dts_pkg::CH_LBRACE) begin
               mode_in = MODE_SEL;
               half_in = 1'b0;
            end else begin
               cand_v[0] = 1'b1;
               cand[0]   = dts_pkg::make_rsp(dts_pkg::KIND_LB, begin_ff, LEN_ONE, 1'b0);
               restart   = 1'b1;
            end
         end
         MODE_UND: begin
            if (c == dts_pkg::CH_UNDER) begin
               mode_in = MODE_CODE;
               half_in = 1'b0;
            end else if (dts_pkg::is_word(c)) begin
               mode_in = MODE_IDENT;
               kwp_in  = 3'd0;
               kwb_in  = 1'b1;
            end else begin
               cand_v[0] = 1'b1;
               cand[0]   = dts_pkg::make_rsp(dts_pkg::KIND_IDENT, begin_ff, LEN_ONE, 1'b0);
               restart   = 1'b1;
            end
         end
         MODE_DASH: begin
            cand_v[0] = 1'b1;
            if (c == dts_pkg::CH_GT) begin
               cand[0] = dts_pkg::make_rsp(dts_pkg::KIND_ARROW, begin_ff, LEN_TWO, 1'b0);
               mode_in = MODE_IDLE;
            end else begin
               cand[0] = dts_pkg::make_rsp(dts_pkg::KIND_BAD, begin_ff, LEN_ONE, 1'b0);
               restart = 1'b1;
            end
         end
         MODE_IDENT: begin
            if (dts_pkg::is_word(c)) begin
               if (!kwb_ff && kwp_ff < dts_pkg::KW_LENGTH && c == dts_pkg::kw_char(kwp_ff)) begin
                  kwp_in = kwp_ff + 3'd1;
               end else begin
                  kwb_in = 1'b1;
               end
            end else begin
               cand_v[0] = 1'b1;
               cand[0]   = dts_pkg::make_rsp(ident_kind, begin_ff,
                                             dts_pkg::span({1'b0, pos_ff}, begin_ff), 1'b0);
               restart   = 1'b1;
            end
         end
         MODE_SEL, MODE_CODE: begin
            if (mode_ff == MODE_CODE) begin
               closer   = dts_pkg::CH_UNDER;
               blk_kind = dts_pkg::KIND_CODE;
            end
            if (c == closer) begin
               if (half_ff) begin
                  cand_v[0] = 1'b1;
                  cand[0]   = dts_pkg::make_rsp(blk_kind, begin_ff,
                                                dts_pkg::span(endp, begin_ff), 1'b0);
                  mode_in   = MODE_IDLE;
                  half_in   = 1'b0;
               end else begin
                  half_in = 1'b1;
               end
            end else begin
               half_in = 1'b0;
            end
         end
         default: begin
            restart = 1'b1;
         end
      endcase

      // Start of a new token at the current byte.
      if (restart) begin
         mode_in = MODE_IDLE;
         if (!dts_pkg::is_space(c)) begin
            begin_in = pos_ff;
            half_in  = 1'b0;
            if (c == dts_pkg::CH_LBRACE) begin
               mode_in = MODE_LB;
            end else if (c == dts_pkg::CH_UNDER) begin
               mode_in = MODE_UND;
            end else if (c == dts_pkg::CH_DASH) begin
               mode_in = MODE_DASH;
            end else if (dts_pkg::is_alpha(c)) begin
               mode_in = MODE_IDENT;
               kwp_in  = (c == dts_pkg::CH_LOW_L) ? 3'd1 : 3'd0;
               kwb_in  = (c != dts_pkg::CH_LOW_L);
            end else begin
               cand_v[1] = 1'b1;
               if (c == dts_pkg::CH_RBRACE) begin
                  cand[1] = dts_pkg::make_rsp(dts_pkg::KIND_RB, pos_ff, LEN_ONE, 1'b0);
               end else if (c == dts_pkg::CH_COLON) begin
                  cand[1] = dts_pkg::make_rsp(dts_pkg::KIND_COLON, pos_ff, LEN_ONE, 1'b0);
               end else if (c == dts_pkg::CH_COMMA) begin
                  cand[1] = dts_pkg::make_rsp(dts_pkg::KIND_COMMA, pos_ff, LEN_ONE, 1'b0);
               end else begin
                  cand[1] = dts_pkg::make_rsp(dts_pkg::KIND_BAD, pos_ff, LEN_ONE, 1'b0);
               end
            end
         end
      end

      pos_in = (pos_ff < POS_MAX) ? pos_ff + OB'(1) : POS_MAX;

      if (last) begin
         cand_v[2] = (mode_in != MODE_IDLE);
         unique case (mode_in) inside
            MODE_LB: begin
               cand[2] = dts_pkg::make_rsp(dts_pkg::KIND_LB, begin_in, LEN_ONE, 1'b0);
            end
            MODE_UND: begin
               cand[2] = dts_pkg::make_rsp(dts_pkg::KIND_IDENT, begin_in, LEN_ONE, 1'b0);
            end
            MODE_DASH: begin
               cand[2] = dts_pkg::make_rsp(dts_pkg::KIND_BAD, begin_in, LEN_ONE, 1'b0);
            end
            MODE_IDENT: begin
               cand[2] = dts_pkg::make_rsp(
                  (!kwb_in && kwp_in == dts_pkg::KW_LENGTH) ?
                     dts_pkg::KIND_LISTEN : dts_pkg::KIND_IDENT,
                  begin_in, dts_pkg::span(endp, begin_in), 1'b0);
            end
            MODE_SEL, MODE_CODE: begin
               cand[2] = dts_pkg::make_rsp(dts_pkg::KIND_BAD, begin_in,
                                           dts_pkg::span(endp, begin_in), 1'b0);
            end
            default: begin
               cand[2] = '0;
            end
         endcase
         cand_v[3] = 1'b1;
         cand[3]   = dts_pkg::make_rsp(dts_pkg::KIND_EOF, pos_in, '0, 1'b1);
         // The next byte starts a new source.
         mode_in  = MODE_IDLE;
         begin_in = '0;
         pos_in   = '0;
         kwp_in   = 3'd0;
         kwb_in   = 1'b0;
         half_in  = 1'b0;
      end
   end

   // Pack the valid candidates into consecutive queue slots.
   always_comb begin
      slot[0] = 2'd0;
      for (int i = 1; i < 4; i++) begin
         slot[i] = slot[i-1] + {1'b0, cand_v[i-1]};
      end
      push_n = 3'(cand_v[0]) + 3'(cand_v[1]) + 3'(cand_v[2]) + 3'(cand_v[3]);
   end

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (rsp_fire) begin
         head_in = head_ff + dts_pkg::QPTR_BITS'(1);
      end
      if (req_fire) begin
         tail_in = tail_ff + dts_pkg::QPTR_BITS'(push_n);
      end
      count_in = count_ff + (req_fire ? dts_pkg::QCNT_BITS'(push_n) : '0)
                 - (rsp_fire ? dts_pkg::QCNT_BITS'(1) : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         begin_ff <= '0;
         pos_ff   <= '0;
         kwp_ff   <= 3'd0;
         kwb_ff   <= 1'b0;
         half_ff  <= 1'b0;
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (req_fire) begin
            mode_ff  <= mode_in;
            begin_ff <= begin_in;
            pos_ff   <= pos_in;
            kwp_ff   <= kwp_in;
            kwb_ff   <= kwb_in;
            half_ff  <= half_in;
         end
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         for (int i = 0; i < 4; i++) begin
            if (cand_v[i]) begin
               queue_ff[tail_ff + dts_pkg::QPTR_BITS'(slot[i])] <= cand[i];
            end
         end
      end
   end

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= dts_pkg::QCNT_BITS'(dts_pkg::QUEUE_DEPTH))
      else $error("result queue holds more entries than its depth");

   a_source_restart: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_data.end_of_source |=> pos_ff == '0 && mode_ff == MODE_IDLE)
      else $error("scan state not cleared after the last byte of a source");

   a_final_is_eof: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.final_token |->
         rsp_data.token_kind == dts_pkg::KIND_EOF && rsp_data.token_length == '0)
      else $error("final token is not an empty end-of-file token");

   a_push_bound: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> push_n <= 3'd3)
      else $error("one byte produced more than three tokens");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      !req_fire && !rsp_fire |=> $stable(count_ff))
      else $error("queue count changed without a transfer");

endmodule

[verif/dsl_token_scanner_checker.sv]
// Token checker for the DSL token scanner: predicts tokens per byte transfer and compares.
`timescale 1ns / 1ps
module dsl_token_scanner_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  dts_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  dts_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               tokens_waiting
);

   localparam int OB = dts_pkg::OFFSET_BITS;

   typedef enum logic [2:0] {
      SCAN_IDLE,
      SCAN_LBRACE,
      SCAN_UNDER,
      SCAN_DASH,
      SCAN_WORD,
      SCAN_SELECTOR,
      SCAN_CODE
   } scan_mode_type;

   localparam logic [47:0] KEYWORD  = "listen";
   localparam logic [OB:0] LEN_ZERO = '0;
   localparam logic [OB:0] LEN_ONE  = {{OB{1'b0}}, 1'b1};
   localparam logic [OB:0] LEN_TWO  = {{(OB - 1){1'b0}}, 2'd2};

   scan_mode_type    mode;
   logic [OB-1:0]    tok_start;
   logic [OB-1:0]    next_pos;
   logic [2:0]       kw_matched;
   logic             kw_dead;
   logic             half_closer;
   dts_pkg::rsp_type expected_tokens[$];

   function automatic logic blank_char(input logic [7:0] c);
      return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic logic letter_char(input logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
   endfunction

   function automatic logic word_char(input logic [7:0] c);
      return letter_char(c) || (c >= "0" && c <= "9") || (c == dts_pkg::CH_UNDER);
   endfunction

   function automatic logic [15:0] clip_field(input logic [OB:0] v);
      return (v > (OB + 1)'(16'hFFFF)) ? 16'hFFFF : v[15:0];
   endfunction

   function automatic logic [OB:0] span_len(input logic [OB:0] stop,
                                            input logic [OB-1:0] from);
      logic [OB:0] base;
      base = {1'b0, from};
      return (stop > base) ? stop - base : '0;
   endfunction

   task automatic clear_scan();
      mode = SCAN_IDLE;
      tok_start = '0;
      next_pos = '0;
      kw_matched = '0;
      kw_dead = 1'b0;
      half_closer = 1'b0;
   endtask

   task automatic push_token(input logic [3:0] kind, input logic [OB-1:0] at,
                             input logic [OB:0] len, input logic fin);
      dts_pkg::rsp_type t;
      t.token_kind   = kind;
      t.token_offset = clip_field({1'b0, at});
      t.token_length = clip_field(len);
      t.final_token  = fin;
      expected_tokens.insert(expected_tokens.size(), t);
   endtask

   task automatic finish_word(input logic [OB:0] stop);
      logic [3:0] kind;
      kind = (!kw_dead && kw_matched == dts_pkg::KW_LENGTH) ?
             dts_pkg::KIND_LISTEN : dts_pkg::KIND_IDENT;
      push_token(kind, tok_start, span_len(stop, tok_start), 1'b0);
   endtask

   task automatic begin_token(input logic [7:0] c, input logic [OB-1:0] at);
      mode = SCAN_IDLE;
      if (!blank_char(c)) begin
         tok_start = at;
         half_closer = 1'b0;
         if (c == dts_pkg::CH_LBRACE) mode = SCAN_LBRACE;
         else if (c == dts_pkg::CH_UNDER) mode = SCAN_UNDER;
         else if (c == dts_pkg::CH_DASH) mode = SCAN_DASH;
         else if (letter_char(c)) begin
            mode = SCAN_WORD;
            kw_matched = (c == dts_pkg::CH_LOW_L) ? 3'd1 : 3'd0;
            kw_dead = (c != dts_pkg::CH_LOW_L);
         end
         else if (c == dts_pkg::CH_RBRACE) push_token(dts_pkg::KIND_RB, at, LEN_ONE, 1'b0);
         else if (c == dts_pkg::CH_COLON) push_token(dts_pkg::KIND_COLON, at, LEN_ONE, 1'b0);
         else if (c == dts_pkg::CH_COMMA) push_token(dts_pkg::KIND_COMMA, at, LEN_ONE, 1'b0);
         else push_token(dts_pkg::KIND_BAD, at, LEN_ONE, 1'b0);
      end
   endtask

   // Selector and code bodies end on the first doubled closer character.
   task automatic block_byte(input logic [7:0] c, input logic [7:0] closer,
                             input logic [3:0] kind, input logic [OB:0] stop);
      if (c == closer) begin
         if (half_closer) begin
            push_token(kind, tok_start, span_len(stop, tok_start), 1'b0);
            mode = SCAN_IDLE;
            half_closer = 1'b0;
         end else begin
            half_closer = 1'b1;
         end
      end else begin
         half_closer = 1'b0;
      end
   endtask

   task automatic scan_byte(input dts_pkg::req_type item);
      logic [7:0]    c;
      logic [OB-1:0] at;
      logic [OB:0]   stop;
      c = item.source_byte;
      at = next_pos;
      stop = {1'b0, at} + 1'b1;
      case (mode)
         SCAN_LBRACE: begin
            if (c == dts_pkg::CH_LBRACE) begin
               mode = SCAN_SELECTOR;
               half_closer = 1'b0;
            end else begin
               push_token(dts_pkg::KIND_LB, tok_start, LEN_ONE, 1'b0);
               begin_token(c, at);
            end
         end
         SCAN_UNDER: begin
            if (c == dts_pkg::CH_UNDER) begin
               mode = SCAN_CODE;
               half_closer = 1'b0;
            end else if (word_char(c)) begin
               mode = SCAN_WORD;
               kw_matched = 3'd0;
               kw_dead = 1'b1;
            end else begin
               push_token(dts_pkg::KIND_IDENT, tok_start, LEN_ONE, 1'b0);
               begin_token(c, at);
            end
         end
         SCAN_DASH: begin
            if (c == dts_pkg::CH_GT) begin
               push_token(dts_pkg::KIND_ARROW, tok_start, LEN_TWO, 1'b0);
               mode = SCAN_IDLE;
            end else begin
               push_token(dts_pkg::KIND_BAD, tok_start, LEN_ONE, 1'b0);
               begin_token(c, at);
            end
         end
         SCAN_WORD: begin
            if (word_char(c)) begin
               if (!kw_dead && kw_matched < dts_pkg::KW_LENGTH &&
                   c == KEYWORD[47 - 8 * kw_matched -: 8])
                  kw_matched = kw_matched + 3'd1;
               else
                  kw_dead = 1'b1;
            end else begin
               finish_word({1'b0, at});
               begin_token(c, at);
            end
         end
         SCAN_SELECTOR: block_byte(c, dts_pkg::CH_RBRACE, dts_pkg::KIND_SEL, stop);
         SCAN_CODE:     block_byte(c, dts_pkg::CH_UNDER, dts_pkg::KIND_CODE, stop);
         default:       begin_token(c, at);
      endcase

      if (at != {OB{1'b1}}) next_pos = at + 1'b1;

      if (item.end_of_source) begin
         case (mode)
            SCAN_LBRACE:   push_token(dts_pkg::KIND_LB, tok_start, LEN_ONE, 1'b0);
            SCAN_UNDER:    push_token(dts_pkg::KIND_IDENT, tok_start, LEN_ONE, 1'b0);
            SCAN_DASH:     push_token(dts_pkg::KIND_BAD, tok_start, LEN_ONE, 1'b0);
            SCAN_WORD:     finish_word(stop);
            SCAN_SELECTOR,
            SCAN_CODE:     push_token(dts_pkg::KIND_BAD, tok_start,
                                      span_len(stop, tok_start), 1'b0);
            default:       ;
         endcase
         push_token(dts_pkg::KIND_EOF, next_pos, LEN_ZERO, 1'b1);
         clear_scan();
      end
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      dts_pkg::rsp_type want;
      if (reset) begin
         clear_scan();
         expected_tokens.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_tokens.size() == 0) begin
               $error("token transfer with nothing expected: kind %0d, offset %0d",
                      rsp_data.token_kind, rsp_data.token_offset);
               fail_count++;
            end else begin
               want = expected_tokens.pop_front();
               check_field("token_kind", 16'(want.token_kind), 16'(rsp_data.token_kind));
               check_field("token_offset", want.token_offset, rsp_data.token_offset);
               check_field("token_length", want.token_length, rsp_data.token_length);
               check_field("final_token", 16'(want.final_token), 16'(rsp_data.final_token));
            end
         end
         if (req_valid && req_ready) scan_byte(req_data);
      end
      tokens_waiting = expected_tokens.size();
   end

endmodule

[verif/dsl_token_scanner_test.sv]
// Top of the DSL token scanner testbench: clock, reset, byte stimulus, stalls and verdict.
`timescale 1ns / 1ps
module dsl_token_scanner_test;

   localparam int STALL_LIMIT  = 2000;
   localparam int RANDOM_BYTES = 440;
   // Length of the closing selector body that is sent without idling.
   localparam int TAIL_FILLER  = 20;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   dts_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   dts_pkg::rsp_type rsp_data;
   int               fail_count;
   int               tokens_waiting;

   dts_pkg::req_type source_bytes[$];
   logic [7:0]       text[$];
   int               tail_start;
   bit               calm = 1'b0;
   int               idle_cycles = 0;

   dsl_token_scanner DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   dsl_token_scanner_checker token_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .fail_count     (fail_count),
      .tokens_waiting (tokens_waiting)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   task automatic put_char(input logic [7:0] c);
      text.insert(text.size(), c);
   endtask

   task automatic put_string(input string s);
      for (int i = 0; i < s.len(); i++) put_char(s[i]);
   endtask

   // Moves the collected text into the byte list, flagging its last byte.
   task automatic end_source();
      dts_pkg::req_type item;
      foreach (text[i]) begin
         item.source_byte = text[i];
         item.end_of_source = (i == text.size() - 1);
         source_bytes.insert(source_bytes.size(), item);
      end
      text.delete();
   endtask

   function automatic logic [7:0] word_byte();
      case ($urandom_range(0, 3))
         0:       return 8'h61 + 8'($urandom_range(0, 25));
         1:       return 8'h41 + 8'($urandom_range(0, 25));
         2:       return 8'h30 + 8'($urandom_range(0, 9));
         default: return dts_pkg::CH_UNDER;
      endcase
   endfunction

   function automatic logic [7:0] blank_byte();
      return ($urandom_range(0, 5) == 0) ? 8'h20 : 8'h09 + 8'($urandom_range(0, 4));
   endfunction

   task automatic put_body(input int n);
      repeat (n) begin
         case ($urandom_range(0, 5))
            0:       put_char(dts_pkg::CH_LBRACE);
            1:       put_char(dts_pkg::CH_RBRACE);
            2:       put_char(dts_pkg::CH_UNDER);
            3:       put_char(blank_byte());
            4:       put_char(word_byte());
            default: put_char(8'($urandom_range(0, 255)));
         endcase
      end
   endtask

   // Mostly well-formed tokens; missing closers and stray bytes now and then.
   task automatic put_token();
      case ($urandom_range(0, 15))
         0, 1: begin
            put_string("{{");
            put_body($urandom_range(0, 6));
            if ($urandom_range(0, 7) != 0) put_string("}}");
         end
         2, 3: begin
            put_string("__");
            put_body($urandom_range(0, 6));
            if ($urandom_range(0, 7) != 0) put_string("__");
         end
         4: put_string("->");
         5: put_string("listen");
         6: begin
            case ($urandom_range(0, 3))
               0:       put_string("lis");
               1:       put_string("listens");
               2:       put_string("liste_n");
               default: put_string("Listen");
            endcase
         end
         7, 8: begin
            put_char(($urandom_range(0, 4) == 0) ?
                     dts_pkg::CH_UNDER : 8'h61 + 8'($urandom_range(0, 25)));
            repeat ($urandom_range(0, 8)) put_char(word_byte());
         end
         9:  put_char(dts_pkg::CH_LBRACE);
         10: put_char(dts_pkg::CH_RBRACE);
         11: put_char(dts_pkg::CH_COLON);
         12: put_char(dts_pkg::CH_COMMA);
         13: put_char(blank_byte());
         14: put_char(8'($urandom_range(0, 255)));
         default: put_char(($urandom_range(0, 1) == 0) ? dts_pkg::CH_DASH : dts_pkg::CH_UNDER);
      endcase
   endtask

   initial begin : stimulus
      int               first_random;
      int               src_len;
      dts_pkg::req_type item;
      bit               new_source;

      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;

      put_string("____");   end_source();
      put_string("{{{{}}"); end_source();
      put_string("{{a}");   end_source();
      put_string("__");     end_source();
      put_string("-}");     end_source();
      put_string("{a->_ ,:"); end_source();
      put_string("listen\r");
      put_char(8'hFF);
      put_string("lis");    end_source();
      put_string("_");      end_source();
      put_string("-");      end_source();

      first_random = source_bytes.size();
      while (source_bytes.size() < first_random + RANDOM_BYTES) begin
         src_len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 30);
         while (text.size() < src_len) begin
            put_token();
            if ($urandom_range(0, 2) == 0) put_char(8'h20);
         end
         end_source();
      end

      tail_start = source_bytes.size();
      put_string("{{");
      repeat (TAIL_FILLER) put_char(8'h61 + 8'($urandom_range(0, 25)));
      put_string("}}ab:");
      end_source();

      repeat (6) @(negedge clock);
      reset <= 1'b0;
      new_source = 1'b1;
      foreach (source_bytes[i]) begin
         item = source_bytes[i];
         if (new_source) calm = (i >= tail_start) || ($urandom_range(0, 3) == 0);
         if (!calm && $urandom_range(0, 4) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clock);
         end
         req_valid <= 1'b1;
         req_data <= item;
         @(posedge clock);
         while (!req_ready) @(posedge clock);
         @(negedge clock);
         new_source = item.end_of_source;
      end
      req_valid <= 1'b0;

      while (tokens_waiting != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin : rsp_side
      rsp_ready = 1'b0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(0, 15)) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // A transfer on either side proves progress.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= STALL_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
